// ----- rtl/core/imfn_pkg.sv -----
package imfn_pkg;

  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned ADDR_W  = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned VERT_W  = 3 * COORD_W;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned EDGE_W  = COORD_W + 1;
  localparam int unsigned MUL_W   = EDGE_W;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned CROSS_W = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned FRAC_W  = 14;
  localparam int unsigned QUO_W   = FRAC_W + 1;
  localparam int unsigned NUM_W   = COORD_W + QUO_W;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_VERTEX   = 2'd1,
    OP_TRIANGLE = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_CROSS,
    S_ABS,
    S_SCALE,
    S_SQUARE,
    S_ROOT,
    S_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ----- rtl/core/imfn_vstore.sv -----
module imfn_vstore (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [imfn_pkg::ADDR_W-1:0]      wr_addr_i,
  input  logic [imfn_pkg::VERT_W-1:0]      wr_data_i,
  input  logic                             rd_en_i,
  input  logic [imfn_pkg::ADDR_W-1:0]      rd_addr_i,
  output logic [imfn_pkg::VERT_W-1:0]      rd_data_o
);
  import imfn_pkg::*;

  logic [VERT_W-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/imfn_mul.sv -----
module imfn_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [imfn_pkg::MUL_W-1:0]    a_i,
  input  logic [imfn_pkg::MUL_W-1:0]    b_i,
  output imfn_pkg::unit_status_t        status_o,
  output logic [imfn_pkg::PROD_W-1:0]   prod_o
);
  import imfn_pkg::*;

  localparam int unsigned CW = $clog2(MUL_W);

  logic [PROD_W-1:0] acc_q, a_q;
  logic [MUL_W-1:0]  b_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= {{(PROD_W - MUL_W){1'b0}}, a_i};
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[PROD_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[MUL_W-1:1]};
    end
  end

  assign status_o = '{busy: busy_q, done: done_q};
  assign prod_o   = acc_q;

endmodule

// ----- rtl/core/imfn_sqrt.sv -----
module imfn_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [imfn_pkg::SUM_W-1:0]    val_i,
  output imfn_pkg::unit_status_t        status_o,
  output logic [imfn_pkg::ROOT_W-1:0]   root_o
);
  import imfn_pkg::*;

  localparam int unsigned CW    = $clog2(ROOT_W);
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned TRY_W = ROOT_W + 4;

  logic [SUM_W-1:0]  val_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [TRY_W-1:0]  rem_n, trial;
  logic              fits;

  always_comb begin
    rem_n = {rem_q, val_q[SUM_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    fits  = rem_n >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[SUM_W-3:0], 2'b00};
      rem_q  <= fits ? REM_W'(rem_n - trial) : REM_W'(rem_n);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign status_o = '{busy: busy_q, done: done_q};
  assign root_o   = root_q;

endmodule

// ----- rtl/core/imfn_div.sv -----
module imfn_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [imfn_pkg::NUM_W-1:0]    num_i,
  input  logic [imfn_pkg::ROOT_W-1:0]   den_i,
  output imfn_pkg::unit_status_t        status_o,
  output logic [imfn_pkg::QUO_W-1:0]    quo_o
);
  import imfn_pkg::*;

  localparam int unsigned CW = $clog2(QUO_W);

  logic [ROOT_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0]  lo_q, quo_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [ROOT_W:0]   r2;
  logic              fits;

  always_comb begin
    r2   = {rem_q, lo_q[QUO_W-1]};
    fits = r2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient stays below 2^QUO_W, so the top part of the numerator is already below den
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ROOT_W'(num_i[NUM_W-1:QUO_W]);
      lo_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? ROOT_W'(r2 - {1'b0, den_q}) : ROOT_W'(r2);
      lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign status_o = '{busy: busy_q, done: done_q};
  assign quo_o    = quo_q;

endmodule

// ----- rtl/core/indexed_mesh_facet_normal.sv -----
// Indexed mesh facet builder with unit normal.
// Input channel (in_valid_i / in_ready_o) takes one transaction per item:
// op 0 clears the vertex count, op 1 stores coord_x/y/z in the next free
// slot (dropped once 4096 are held), op 2 carries three vertex indices.
// Start and vertex transactions give no result. A triangle with a
// negative index or one at or above the count is dropped. Otherwise
// the three corners are read from the vertex memory (one read port),
// the cross product is formed by a bit-serial multiplier (6 products),
// scaled one bit per cycle, squared (3 products), rooted by a bit-serial
// square root and divided three times by a bit-serial divider. A zero
// cross product skips squaring, root and divide. Nine multiplier passes
// dominate the time to a valid result; scaling sets the spread.
// The result sits in an output register (out_valid_o / out_ready_i);
// while it is stalled the block still takes further transactions and
// finishes the next triangle, then holds until the register frees.
// Reset empties the mesh and drops any result; memory contents persist.
module indexed_mesh_facet_normal (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            op_i,
  input  logic signed [imfn_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [imfn_pkg::COORD_W-1:0]   coord_y_i,
  input  logic signed [imfn_pkg::COORD_W-1:0]   coord_z_i,
  input  logic signed [imfn_pkg::IDX_W-1:0]     index_first_i,
  input  logic signed [imfn_pkg::IDX_W-1:0]     index_second_i,
  input  logic signed [imfn_pkg::IDX_W-1:0]     index_third_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [imfn_pkg::COORD_W-1:0]   ax_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   ay_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   az_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   bx_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   by__o,
  output logic signed [imfn_pkg::COORD_W-1:0]   bz_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   cx_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   cy_o,
  output logic signed [imfn_pkg::COORD_W-1:0]   cz_o,
  output logic signed [imfn_pkg::NORM_W-1:0]    normal_x_o,
  output logic signed [imfn_pkg::NORM_W-1:0]    normal_y_o,
  output logic signed [imfn_pkg::NORM_W-1:0]    normal_z_o
);
  import imfn_pkg::*;

  state_e state_q, state_d;
  logic [2:0]          step_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ADDR_W-1:0]   idx_q [3];
  logic [VERT_W-1:0]   vert_q [3];
  logic signed [CROSS_W-1:0] n_q [3];
  logic [CROSS_W-1:0]  mag_q [3];
  logic [2:0]          neg_q;
  logic [SUM_W-1:0]    sum_q;
  logic [ROOT_W-1:0]   len_q;
  logic [NORM_W-1:0]   nrm_q [3];
  logic                msgn_q;
  logic                out_valid_q;
  logic [COORD_W-1:0]  o_crd_q [9];
  logic [NORM_W-1:0]   o_nrm_q [3];

  logic in_acc, tri_ok, out_free;
  logic mul_start, sqrt_start, div_start, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [VERT_W-1:0] rd_data;
  unit_status_t mul_st, sqrt_st, div_st;
  logic [PROD_W-1:0] prod;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo;
  logic signed [EDGE_W-1:0] opa, opb;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [CROSS_W-1:0] orv;
  logic signed [CROSS_W-1:0] term;
  logic [NUM_W-1:0] num;
  logic [1:0] sel;

  function automatic logic signed [EDGE_W-1:0] edge_c(input logic [VERT_W-1:0] va,
                                                      input logic [VERT_W-1:0] vb,
                                                      input logic [1:0] c);
    logic signed [COORD_W-1:0] a, b;
    a = signed'(va[c*COORD_W +: COORD_W]);
    b = signed'(vb[c*COORD_W +: COORD_W]);
    return EDGE_W'(a) - EDGE_W'(b);
  endfunction

  function automatic logic [MUL_W-1:0] abs_e(input logic signed [EDGE_W-1:0] v);
    return v[EDGE_W-1] ? MUL_W'(-v) : MUL_W'(v);
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign sel        = step_q[1:0];
  assign tri_ok     = ({1'b0, index_first_i}  < {1'b0, cnt_q}) &&
                      ({1'b0, index_second_i} < {1'b0, cnt_q}) &&
                      ({1'b0, index_third_i}  < {1'b0, cnt_q});

  // edge 1 = v1 - v0, edge 2 = v2 - v0; coordinate 0 is x
  always_comb begin
    opa = '0;
    opb = '0;
    case (step_q)
      3'd0: begin
        opa = edge_c(vert_q[1], vert_q[0], 2'd1);
        opb = edge_c(vert_q[2], vert_q[0], 2'd2);
      end
      3'd1: begin
        opa = edge_c(vert_q[2], vert_q[0], 2'd1);
        opb = edge_c(vert_q[1], vert_q[0], 2'd2);
      end
      3'd2: begin
        opa = edge_c(vert_q[1], vert_q[0], 2'd2);
        opb = edge_c(vert_q[2], vert_q[0], 2'd0);
      end
      3'd3: begin
        opa = edge_c(vert_q[1], vert_q[0], 2'd0);
        opb = edge_c(vert_q[2], vert_q[0], 2'd2);
      end
      3'd4: begin
        opa = edge_c(vert_q[1], vert_q[0], 2'd0);
        opb = edge_c(vert_q[2], vert_q[0], 2'd1);
      end
      3'd5: begin
        opa = edge_c(vert_q[2], vert_q[0], 2'd0);
        opb = edge_c(vert_q[1], vert_q[0], 2'd1);
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    if (state_q == S_SQUARE) begin
      mul_a = (sel == 2'd3) ? '0 : {1'b0, mag_q[sel][COORD_W-1:0]};
      mul_b = mul_a;
    end else begin
      mul_a = abs_e(opa);
      mul_b = abs_e(opb);
    end
  end

  assign orv  = mag_q[0] | mag_q[1] | mag_q[2];
  assign term = msgn_q ? -signed'({1'b0, prod}) : signed'({1'b0, prod});
  assign num  = {1'b0, ((sel == 2'd3) ? {COORD_W{1'b0}} : mag_q[sel][COORD_W-1:0]),
                 {FRAC_W{1'b0}}}
              + NUM_W'(len_q[ROOT_W-1:1]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && op_i == OP_TRIANGLE && tri_ok) state_d = S_FETCH;
      S_FETCH:  if (step_q == 3'd3) state_d = S_CROSS;
      S_CROSS:  if (mul_st.done && step_q == 3'd5) state_d = S_ABS;
      S_ABS:    state_d = S_SCALE;
      S_SCALE: begin
        if (orv == '0) state_d = S_EMIT;
        else if (orv[CROSS_W-1:COORD_W] == '0 && orv[COORD_W-1]) state_d = S_SQUARE;
      end
      S_SQUARE: if (mul_st.done && step_q == 3'd2) state_d = S_ROOT;
      S_ROOT:   if (sqrt_st.done) state_d = S_DIV;
      S_DIV:    if (div_st.done && step_q == 3'd2) state_d = S_EMIT;
      S_EMIT:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state_q)
      S_FETCH: begin
        rd_en   = (step_q != 3'd3);
        rd_addr = (sel == 2'd3) ? '0 : idx_q[sel];
      end
      S_CROSS, S_SQUARE: mul_start = !mul_st.busy && !mul_st.done;
      S_ROOT:  sqrt_start = !sqrt_st.busy && !sqrt_st.done;
      S_DIV:   div_start  = !div_st.busy && !div_st.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        step_q <= '0;
      end else if (state_q == S_FETCH || mul_st.done || div_st.done) begin
        step_q <= step_q + 1'b1;
      end
      if (in_acc) begin
        if (op_i == OP_START) begin
          cnt_q <= '0;
        end else if (op_i == OP_VERTEX && cnt_q < CNT_W'(MAX_VERTICES)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q[0] <= index_first_i[ADDR_W-1:0];
      idx_q[1] <= index_second_i[ADDR_W-1:0];
      idx_q[2] <= index_third_i[ADDR_W-1:0];
    end
    if (state_q == S_FETCH && step_q != 3'd0) begin
      vert_q[sel - 2'd1] <= rd_data;
    end
    if (mul_start) begin
      msgn_q <= opa[EDGE_W-1] ^ opb[EDGE_W-1];
    end
    if (state_q == S_CROSS && mul_st.done) begin
      n_q[step_q[2:1]] <= step_q[0] ? n_q[step_q[2:1]] - term : term;
    end
    if (state_q == S_ABS) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= n_q[i][CROSS_W-1] ? CROSS_W'(-n_q[i]) : CROSS_W'(n_q[i]);
        neg_q[i] <= n_q[i][CROSS_W-1];
      end
      sum_q <= '0;
    end
    if (state_q == S_SCALE) begin
      if (orv == '0) begin
        for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
      end else if (orv[CROSS_W-1:COORD_W] != '0) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= {1'b0, mag_q[i][CROSS_W-1:1]};
      end else if (!orv[COORD_W-1]) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= {mag_q[i][CROSS_W-2:0], 1'b0};
      end
    end
    if (state_q == S_SQUARE && mul_st.done) begin
      sum_q <= sum_q + prod;
    end
    if (sqrt_st.done) begin
      len_q <= root;
    end
    if (state_q == S_DIV && div_st.done && sel != 2'd3) begin
      nrm_q[sel] <= neg_q[sel] ? NORM_W'(-{1'b0, quo}) : NORM_W'({1'b0, quo});
    end
    if (state_q == S_EMIT && out_free) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          o_crd_q[i*3 + c] <= vert_q[i][c*COORD_W +: COORD_W];
        end
        o_nrm_q[i] <= nrm_q[i];
      end
    end
  end

  imfn_vstore u_vstore (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && op_i == OP_VERTEX && cnt_q < CNT_W'(MAX_VERTICES)),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i ({coord_z_i, coord_y_i, coord_x_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  imfn_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .status_o (mul_st),
    .prod_o   (prod)
  );

  imfn_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .val_i    (sum_q),
    .status_o (sqrt_st),
    .root_o   (root)
  );

  imfn_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (num),
    .den_i    (len_q),
    .status_o (div_st),
    .quo_o    (quo)
  );

  assign out_valid_o = out_valid_q;
  assign ax_o  = o_crd_q[0];
  assign ay_o  = o_crd_q[1];
  assign az_o  = o_crd_q[2];
  assign bx_o  = o_crd_q[3];
  assign by__o = o_crd_q[4];
  assign bz_o  = o_crd_q[5];
  assign cx_o  = o_crd_q[6];
  assign cy_o  = o_crd_q[7];
  assign cz_o  = o_crd_q[8];
  assign normal_x_o = o_nrm_q[0];
  assign normal_y_o = o_nrm_q[1];
  assign normal_z_o = o_nrm_q[2];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
                     normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384 &&
                     normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384))
    else $error("normal component out of range");

  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule
